// ===== src/cpbf_pkg.sv =====
// cpbf_pkg: shared types and codes of the command prefix and block pattern filter
// depends on nothing; used by the interfaces, the top level and the checker
package cpbf_pkg;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 7;
  localparam int POS_W    = 5;
  localparam int REASON_W = 2;
  localparam int CNT_W    = 6;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

  localparam logic [REASON_W-1:0] REASON_ALLOW   = 2'd0;
  localparam logic [REASON_W-1:0] REASON_EMPTY   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_BLOCKED = 2'd2;
  localparam logic [REASON_W-1:0] REASON_NOALLOW = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_DECIDE,
    ST_BCMP,
    ST_ALAST,
    ST_APOS,
    ST_POST
  } state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_gap(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_PIPE);
  endfunction

  function automatic logic is_open(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_SLASH);
  endfunction

endpackage

// ===== src/cpbf_if.sv =====
// cpbf_if: valid/ready channel interfaces for input words and result words
// depends on cpbf_pkg for field widths
interface cpbf_in_if;
  import cpbf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [7:0]        data_byte;
  logic [SLOT_W-1:0] pattern_slot;
  logic [POS_W-1:0]  pattern_pos;
  logic              pattern_kind;
  logic              pattern_end;

  modport source (output valid, cmd, data_byte, pattern_slot, pattern_pos, pattern_kind,
                  pattern_end, input ready);
  modport sink (input valid, cmd, data_byte, pattern_slot, pattern_pos, pattern_kind,
                pattern_end, output ready);
endinterface

interface cpbf_out_if;
  import cpbf_pkg::*;
  logic                valid;
  logic                ready;
  logic                verdict;
  logic [REASON_W-1:0] reason;
  logic [SLOT_W-1:0]   matched_slot;

  modport source (output valid, verdict, reason, matched_slot, input ready);
  modport sink (input valid, verdict, reason, matched_slot, output ready);
endinterface

// ===== src/command_prefix_and_block_pattern_filter.sv =====
// a command byte walks every slot: each slot reads its length and decides, and a slot whose
// check runs then compares pattern bytes one at a time against the byte or recent bytes
// end of command: a closing pass over every slot, or none when empty or already blocked
// load words and leading blanks keep the block idle; one pattern memory read port sets the pace
// one word at a time: in_word.ready is low while the slot walk runs
// reset (synchronous, active low) empties every slot and clears the command state
// top level: command prefix and block pattern filter
// depends on cpbf_pkg and the channel interfaces in cpbf_if.sv
module command_prefix_and_block_pattern_filter #(
  parameter int NUM_PATTERNS    = 128,
  parameter int MAX_PATTERN_LEN = 32
) (
  input logic       clk,
  input logic       rst_n,
  cpbf_in_if.sink   in_word,
  cpbf_out_if.source out_word
);
  import cpbf_pkg::*;

  localparam int SW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int PW    = $clog2(MAX_PATTERN_LEN);
  localparam int LW    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int CW    = 8;  // compare width for counts against lengths
  localparam int DEPTH = NUM_PATTERNS << PW;

  // pattern bytes and lengths live in memories, flags in flops
  logic [7:0]    store_mem [DEPTH];
  logic [LW-1:0] len_mem   [NUM_PATTERNS];
  logic [7:0]    store_q;
  logic [LW-1:0] len_q;
  logic [SW+PW-1:0] raddr;

  logic [NUM_PATTERNS-1:0] isblk_r, lenv_r;
  logic [NUM_PATTERNS-1:0] alive_r, alive_nxt;
  logic [7:0] recent_r [MAX_PATTERN_LEN];
  logic [7:0] recent_nxt [MAX_PATTERN_LEN];

  state_t state_r, state_nxt;
  logic [SW-1:0]    s_r, s_nxt;
  logic [PW-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0] p_r, p_nxt, cnt_r, cnt_nxt;
  logic [7:0]       b_r, b_nxt;
  logic             end_r, end_nxt, open_r, open_nxt;
  logic             any_r, any_nxt, bhit_r, bhit_nxt, ahit_r, ahit_nxt;
  logic [SW-1:0]    hit_r, hit_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                verdict_r, verdict_nxt;
  logic [REASON_W-1:0] reason_r, reason_nxt;
  logic [SLOT_W-1:0]   mslot_r, mslot_nxt;

  // handshake and load decode
  logic in_fire, load_ok, blank_skip, out_free;
  assign in_word.ready = (state_r == ST_IDLE);
  assign in_fire       = in_word.valid && in_word.ready;
  assign load_ok       = ({2'b0, in_word.pattern_slot} < 9'(NUM_PATTERNS)) &&
                         ({2'b0, in_word.pattern_pos} < 7'(MAX_PATTERN_LEN));
  assign blank_skip    = (cnt_r == '0) && is_blank(in_word.data_byte);
  assign out_free      = !out_valid_r || out_word.ready;

  // per-slot view during the walk
  logic [LW-1:0] len_eff;
  logic [CW-1:0] len_w, p_w, cnt_w, k_w;
  logic blk_s, alive_s, last_slot, skip, bmism, bdone, p_in, slot_fin;
  logic [LW-1:0] ridx;

  assign len_eff   = lenv_r[s_r] ? len_q : '0;
  assign len_w     = CW'(len_eff);
  assign p_w       = CW'(p_r);
  assign cnt_w     = CW'(cnt_r);
  assign k_w       = CW'(k_r);
  assign blk_s     = isblk_r[s_r];
  assign alive_s   = alive_r[s_r];
  assign last_slot = (s_r == SW'(NUM_PATTERNS - 1));
  assign skip      = (len_eff == '0) || (blk_s ? (cnt_w < len_w) : !alive_s);
  // recent byte facing pattern position k: recent[len-1-k]
  assign ridx      = len_eff - LW'(1) - LW'(k_r);
  assign bmism     = (store_q != recent_r[ridx[PW-1:0]]);
  assign bdone     = bmism || (k_w == len_w - CW'(1));
  assign p_in      = (p_w < len_w);

  always_comb begin
    unique case (state_r)
      ST_DECIDE: slot_fin = end_r || skip;
      ST_BCMP:   slot_fin = bdone;
      ST_ALAST:  slot_fin = !p_in;
      ST_APOS:   slot_fin = 1'b1;
      default:   slot_fin = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_word.cmd == CMD_BYTE && !blank_skip) begin
            state_nxt = ST_META;
          end else if (in_word.cmd == CMD_END) begin
            state_nxt = (!any_r || bhit_r) ? ST_POST : ST_META;
          end
        end
      end
      ST_META: state_nxt = ST_DECIDE;
      ST_DECIDE, ST_BCMP, ST_ALAST, ST_APOS: begin
        if (slot_fin) begin
          if (!last_slot) begin
            state_nxt = ST_META;
          end else begin
            state_nxt = end_r ? ST_POST : ST_IDLE;
          end
        end else if (state_r == ST_DECIDE) begin
          state_nxt = blk_s ? ST_BCMP : ST_ALAST;
        end else if (state_r == ST_ALAST) begin
          state_nxt = ST_APOS;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    s_nxt         = s_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    b_nxt         = b_r;
    end_nxt       = end_r;
    open_nxt      = open_r;
    cnt_nxt       = cnt_r;
    any_nxt       = any_r;
    bhit_nxt      = bhit_r;
    ahit_nxt      = ahit_r;
    hit_nxt       = hit_r;
    alive_nxt     = alive_r;
    recent_nxt    = recent_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    verdict_nxt   = verdict_r;
    reason_nxt    = reason_r;
    mslot_nxt     = mslot_r;
    raddr         = {s_r, k_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_word.cmd == CMD_BYTE) begin
          any_nxt = 1'b1;
          if (!blank_skip) begin
            p_nxt   = cnt_r;
            b_nxt   = in_word.data_byte;
            end_nxt = 1'b0;
            s_nxt   = '0;
            for (int i = MAX_PATTERN_LEN - 1; i > 0; i--) begin
              recent_nxt[i] = recent_r[i-1];
            end
            recent_nxt[0] = in_word.data_byte;
            if (cnt_r < COUNT_MAX) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end else if (in_fire && in_word.cmd == CMD_END) begin
          end_nxt = 1'b1;
          s_nxt   = '0;
        end
      end
      ST_DECIDE: begin
        if (end_r) begin
          // closing pass: alive prefixes whose length equals the count
          if (len_eff != '0 && !blk_s && alive_s && cnt_w == len_w) begin
            if (!ahit_r || s_r < hit_r) begin
              hit_nxt = s_r;
            end
            ahit_nxt = 1'b1;
          end
        end else if (!skip) begin
          k_nxt = '0;
          raddr = blk_s ? {s_r, PW'(0)} : {s_r, PW'(len_eff - LW'(1))};
        end
      end
      ST_BCMP: begin
        if (!bmism && bdone) begin
          if (!bhit_r || s_r < hit_r) begin
            hit_nxt = s_r;
          end
          bhit_nxt = 1'b1;
        end else if (!bdone) begin
          k_nxt = k_r + PW'(1);
          raddr = {s_r, k_r + PW'(1)};
        end
      end
      ST_ALAST: begin
        open_nxt = is_open(store_q);
        if (p_in) begin
          raddr = {s_r, p_r[PW-1:0]};
        end else if (p_w == len_w && !is_open(store_q)) begin
          if (is_gap(b_r)) begin
            if (!bhit_r) begin
              if (!ahit_r || s_r < hit_r) begin
                hit_nxt = s_r;
              end
              ahit_nxt = 1'b1;
            end
          end else begin
            alive_nxt[s_r] = 1'b0;
          end
        end
      end
      ST_APOS: begin
        if (store_q != b_r) begin
          alive_nxt[s_r] = 1'b0;
        end else if (p_w == len_w - CW'(1) && open_r && !bhit_r) begin
          if (!ahit_r || s_r < hit_r) begin
            hit_nxt = s_r;
          end
          ahit_nxt = 1'b1;
        end
      end
      ST_POST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!any_r) begin
            verdict_nxt = 1'b0;
            reason_nxt  = REASON_EMPTY;
            mslot_nxt   = '0;
          end else if (bhit_r) begin
            verdict_nxt = 1'b0;
            reason_nxt  = REASON_BLOCKED;
            mslot_nxt   = SLOT_W'(hit_r);
          end else if (ahit_r) begin
            verdict_nxt = 1'b1;
            reason_nxt  = REASON_ALLOW;
            mslot_nxt   = SLOT_W'(hit_r);
          end else begin
            verdict_nxt = 1'b0;
            reason_nxt  = REASON_NOALLOW;
            mslot_nxt   = '0;
          end
          // command state back to its idle values
          alive_nxt = '1;
          for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            recent_nxt[i] = '0;
          end
          cnt_nxt  = '0;
          any_nxt  = 1'b0;
          bhit_nxt = 1'b0;
          ahit_nxt = 1'b0;
          hit_nxt  = '0;
        end
      end
      default: ;
    endcase

    if (slot_fin && !last_slot) begin
      s_nxt = s_r + SW'(1);
    end
  end

  // memories: one write port from loads, registered reads
  always_ff @(posedge clk) begin
    if (in_fire && in_word.cmd == CMD_LOAD && load_ok) begin
      store_mem[{SW'(in_word.pattern_slot), PW'(in_word.pattern_pos)}] <= in_word.data_byte;
      if (in_word.pattern_end) begin
        len_mem[SW'(in_word.pattern_slot)] <= LW'(in_word.pattern_pos) + LW'(1);
      end
    end
    store_q <= store_mem[raddr];
    len_q   <= len_mem[s_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      isblk_r     <= '0;
      lenv_r      <= '0;
      alive_r     <= '1;
      cnt_r       <= '0;
      any_r       <= 1'b0;
      bhit_r      <= 1'b0;
      ahit_r      <= 1'b0;
      hit_r       <= '0;
      end_r       <= 1'b0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        recent_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      alive_r     <= alive_nxt;
      cnt_r       <= cnt_nxt;
      any_r       <= any_nxt;
      bhit_r      <= bhit_nxt;
      ahit_r      <= ahit_nxt;
      hit_r       <= hit_nxt;
      end_r       <= end_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
      recent_r    <= recent_nxt;
      if (in_fire && in_word.cmd == CMD_LOAD && load_ok) begin
        isblk_r[SW'(in_word.pattern_slot)] <= in_word.pattern_kind;
        if (in_word.pattern_end) begin
          lenv_r[SW'(in_word.pattern_slot)] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    b_r       <= b_nxt;
    open_r    <= open_nxt;
    verdict_r <= verdict_nxt;
    reason_r  <= reason_nxt;
    mslot_r   <= mslot_nxt;
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.verdict      = verdict_r;
  assign out_word.reason       = reason_r;
  assign out_word.matched_slot = mslot_r;

endmodule

// ===== src/cpbf_checker.sv =====
// cpbf_checker: port-level assertions for the filter, bound to the top level
// depends on cpbf_pkg and command_prefix_and_block_pattern_filter
module cpbf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [cpbf_pkg::CMD_W-1:0]    in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_verdict,
  input logic [cpbf_pkg::REASON_W-1:0] out_reason,
  input logic [cpbf_pkg::SLOT_W-1:0]   out_matched_slot
);
  import cpbf_pkg::*;

  // a waiting result word keeps its reason and slot until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reason) && $stable(out_matched_slot))
    else $error("result word changed while stalled");

  // verdict agrees with reason
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == (out_reason == REASON_ALLOW)))
    else $error("verdict and reason disagree");

  // no slot reported for empty or unmatched commands
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reason == REASON_EMPTY || out_reason == REASON_NOALLOW)
      |-> out_matched_slot == '0)
    else $error("slot reported without a hit");

  // end of command starts the verdict pass, so no word is taken next cycle
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_END |=> !in_ready)
    else $error("ready right after end of command");

endmodule

bind command_prefix_and_block_pattern_filter cpbf_checker u_cpbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_word.valid),
  .in_ready         (in_word.ready),
  .in_cmd           (in_word.cmd),
  .out_valid        (out_word.valid),
  .out_ready        (out_word.ready),
  .out_verdict      (out_word.verdict),
  .out_reason       (out_word.reason),
  .out_matched_slot (out_word.matched_slot)
);
